>>> design/led_anim_pkg.sv
`default_nettype none

package led_anim_pkg;

    localparam int LED_COUNT = 8;
    localparam int ADDR_W    = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
    localparam int IDX_W     = 8;
    localparam int LVL_W     = 8;

    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(LED_COUNT - 1);
    localparam logic [LVL_W-1:0]  LVL_FULL  = 8'hFF;

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_TICK  = 2'd2
    } t_op;

    typedef enum logic [1:0] {
        MODE_OFF   = 2'd0,
        MODE_ON    = 2'd1,
        MODE_FLASH = 2'd2,
        MODE_PULSE = 2'd3
    } t_mode;

    typedef enum logic [2:0] {
        COLOR_WHITE = 3'd0,
        COLOR_RED   = 3'd1,
        COLOR_GREEN = 3'd2,
        COLOR_BLUE  = 3'd3
    } t_color;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_TICK
    } t_state;

    typedef struct packed {
        t_op              op;
        logic [IDX_W-1:0] led_index;
        logic [1:0]       mode;
        logic [2:0]       color;
    } t_in_word;

    typedef struct packed {
        logic [IDX_W-1:0] out_index;
        logic [LVL_W-1:0] red;
        logic [LVL_W-1:0] green;
        logic [LVL_W-1:0] blue;
        logic [1:0]       stored_mode;
        logic [2:0]       stored_color;
        logic             last;
    } t_out_word;

    typedef struct packed {
        logic [2:0] color;
        logic [1:0] mode;
    } t_entry;

    typedef struct packed {
        logic [LVL_W-1:0] red;
        logic [LVL_W-1:0] green;
        logic [LVL_W-1:0] blue;
    } t_rgb;

    // Drive level for one mode at the given phase.
    function automatic logic [LVL_W-1:0] level_of(logic [1:0] mode, logic [5:0] phase);
        logic [LVL_W-1:0] lvl;
        lvl = '0;
        case (mode)
            MODE_OFF:   lvl = '0;
            MODE_ON:    lvl = LVL_FULL;
            MODE_FLASH: lvl = phase[3] ? '0 : LVL_FULL;
            // triangle: p*8 rising, (63-p)*8 falling; 63-p is ~p[4:0] in the top half
            MODE_PULSE: lvl = phase[5] ? {~phase[4:0], 3'b000} : {phase[4:0], 3'b000};
            default:    lvl = '0;
        endcase
        return lvl;
    endfunction

    function automatic t_rgb color_apply(logic [2:0] color, logic [LVL_W-1:0] lvl);
        t_rgb rgb;
        rgb = '0;
        case (color)
            COLOR_WHITE: rgb = '{red: lvl, green: lvl, blue: lvl};
            COLOR_RED:   rgb.red   = lvl;
            COLOR_GREEN: rgb.green = lvl;
            COLOR_BLUE:  rgb.blue  = lvl;
            default:     rgb = '0;
        endcase
        return rgb;
    endfunction

endpackage

`default_nettype wire

>>> design/led_effect_animator.sv
`default_nettype none

// LED effect animator. Holds a mode/color entry per LED in a small synchronous
// table plus a 6-bit animation phase. A write word stores one entry (indexes
// past the LED count are dropped). A read word's entry is read from the table
// into a read register and then, once the output register is free, into the
// output register (zeros when out of range); the input is taken again when the
// state returns to idle. A tick word advances the phase and then streams one RGB
// word per LED, in index order, with last set on the final one; the table's
// single read port delivers one entry per cycle while the output is not stalled.
// The input is stalled while a read or tick is in progress; a finished word can
// sit in the output register while the next input word is taken.
module led_effect_animator
    import led_anim_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_word  i_in_word,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_word      o_out_word
);

    t_entry              mem [0:LED_COUNT-1];
    logic [LED_COUNT-1:0] r_vld;

    t_state              r_state, n_state;
    logic [ADDR_W-1:0]   r_cnt, n_cnt;
    logic [5:0]          r_phase, n_phase;
    logic                r_out_valid, n_out_valid;
    t_out_word           r_out_word, n_out_word;
    logic [IDX_W-1:0]    r_rd_idx, n_rd_idx;
    logic                r_rd_inrng, n_rd_inrng;
    t_entry              r_rd_data;
    logic                r_rd_vld;

    logic                rd_en, wr_en;
    logic [ADDR_W-1:0]   rd_addr;
    logic                in_accept, in_rng, out_free;
    logic [ADDR_W-1:0]   in_addr;
    t_entry              entry;
    t_rgb                rgb;

    assign in_accept = i_in_valid && !o_in_stall;
    assign in_rng    = i_in_word.led_index < IDX_W'(LED_COUNT);
    assign in_addr   = i_in_word.led_index[ADDR_W-1:0];
    assign out_free  = !r_out_valid || !i_out_stall;
    // never-written entries read as off/white
    assign entry     = r_rd_vld ? r_rd_data : '0;
    assign rgb       = color_apply(entry.color, level_of(entry.mode, r_phase));

    assign o_in_stall  = (r_state != ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out_word;

    always_comb begin
        n_state     = r_state;
        n_cnt       = r_cnt;
        n_phase     = r_phase;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_word  = r_out_word;
        n_rd_idx    = r_rd_idx;
        n_rd_inrng  = r_rd_inrng;
        rd_en       = 1'b0;
        wr_en       = 1'b0;
        rd_addr     = in_addr;
        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    case (i_in_word.op)
                        OP_WRITE: wr_en = in_rng;
                        OP_READ: begin
                            rd_en      = in_rng;
                            n_rd_idx   = i_in_word.led_index;
                            n_rd_inrng = in_rng;
                            n_state    = ST_READ;
                        end
                        OP_TICK: begin
                            n_phase = r_phase + 6'd1;
                            rd_en   = 1'b1;
                            rd_addr = '0;
                            n_cnt   = '0;
                            n_state = ST_TICK;
                        end
                        default: ;
                    endcase
                end
            end
            ST_READ: begin
                if (out_free) begin
                    n_out_valid              = 1'b1;
                    n_out_word               = '0;
                    n_out_word.out_index     = r_rd_idx;
                    n_out_word.stored_mode   = r_rd_inrng ? entry.mode  : '0;
                    n_out_word.stored_color  = r_rd_inrng ? entry.color : '0;
                    n_out_word.last          = 1'b1;
                    n_state                  = ST_IDLE;
                end
            end
            ST_TICK: begin
                if (out_free) begin
                    n_out_valid          = 1'b1;
                    n_out_word           = '0;
                    n_out_word.out_index = IDX_W'(r_cnt);
                    n_out_word.red       = rgb.red;
                    n_out_word.green     = rgb.green;
                    n_out_word.blue      = rgb.blue;
                    n_out_word.last      = (r_cnt == LAST_ADDR);
                    if (r_cnt == LAST_ADDR) begin
                        n_state = ST_IDLE;
                    end else begin
                        rd_en   = 1'b1;
                        rd_addr = r_cnt + ADDR_W'(1);
                        n_cnt   = r_cnt + ADDR_W'(1);
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_phase     <= '0;
            r_out_valid <= 1'b0;
            r_vld       <= '0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
            if (wr_en) begin
                r_vld[in_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_word <= n_out_word;
        r_rd_idx   <= n_rd_idx;
        r_rd_inrng <= n_rd_inrng;
    end

    // Writes happen only on a write word and reads only on a read or tick word or
    // in the tick state, so a read and a write never hit the table in the same cycle.
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[in_addr] <= '{color: i_in_word.color, mode: i_in_word.mode};
        end
        if (rd_en) begin
            r_rd_data <= mem[rd_addr];
            r_rd_vld  <= r_vld[rd_addr];
        end
    end

endmodule

`default_nettype wire

>>> design/led_anim_chk.sv
`default_nettype none

module led_anim_chk
    import led_anim_pkg::*;
(
    input wire logic      i_clk,
    input wire logic      i_rst_n,
    input wire logic      i_in_valid,
    input wire logic      o_in_stall,
    input wire t_in_word  i_in_word,
    input wire logic      o_out_valid,
    input wire logic      i_out_stall,
    input wire t_out_word o_out_word
);

    a_rst_clears_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid)
        else $error("output valid after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_out_word))
        else $error("stalled output word changed");

    a_read_word_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_out_word.stored_mode != 2'd0 || o_out_word.stored_color != 3'd0)
        |-> o_out_word.red == '0 && o_out_word.green == '0 && o_out_word.blue == '0
            && o_out_word.last)
        else $error("read word carries color or lacks last");

    a_mid_tick_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !o_out_word.last
        |-> o_out_word.stored_mode == 2'd0 && o_out_word.stored_color == 3'd0
            && o_out_word.out_index < IDX_W'(LED_COUNT - 1))
        else $error("bad non-final tick word");

    a_busy_after_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && (i_in_word.op == OP_READ || i_in_word.op == OP_TICK)
        |=> o_in_stall)
        else $error("input not stalled after read or tick");

endmodule

bind led_effect_animator led_anim_chk u_led_anim_chk (.*);

`default_nettype wire
